// ----- hw/rtl/aesgcm_pkg.sv -----
package aesgcm_pkg;

    localparam int KEY_W   = 64;
    localparam int IV_HI_W = 32;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 5;
    localparam int LEN_W   = 61;
    localparam int FIFO_DEPTH = 2;

    localparam logic [IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_IVU  = 3'd4;
    localparam logic [IDX_W-1:0] REG_IVL  = 3'd5;

    // classified item handed from front to back
    typedef struct packed {
        logic [127:0]     data;
        logic [CNT_W-1:0] nbytes;
        logic             last;
    } cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // one full AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i+4*c] = b[i + 4*((c+i) % 4)];
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int i = 0; i < 4; i++)
                o[4*c+i] = mix ? (t[4*c+i] ^ all ^ xtime(t[4*c+i] ^ t[4*c+((i+1)%4)]))
                               : t[4*c+i];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
        aes_round = r ^ rk;
    endfunction

    // byte mask for the first n bytes of a block
    function automatic logic [127:0] byte_mask(input logic [CNT_W-1:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (CNT_W'(i) < n) ? 8'hff : 8'h00;
        byte_mask = m;
    endfunction

endpackage

// ----- hw/rtl/aes256_gcm_encrypt_stream_top.sv -----
// Channel  | Handshake           | Payload
// input    | in_valid / in_stall | block_upper, block_lower, valid_bytes, end_of_message
// output   | out_valid / out_stall | out_upper, out_lower, out_bytes, is_tag, final_result
// config   | cfg_we              | cfg_index, cfg_data
// First item of a message: key expansion, then two 14-round encryptions (H, E(J0)).
// Data item: its rounds run through the single shared AES round, then a
// 4-bit-per-cycle GHASH pass; the tag adds another GHASH pass.
// Reset clears control state; a two-entry queue decouples input from the engine.
// Output stall holds the result register and the engine waits behind it.
module aes256_gcm_encrypt_stream_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [aesgcm_pkg::IDX_W-1:0] cfg_index,
    input  logic [aesgcm_pkg::CFG_W-1:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_upper,
    input  logic [63:0] block_lower,
    input  logic [aesgcm_pkg::CNT_W-1:0] valid_bytes,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_upper,
    output logic [63:0] out_lower,
    output logic [aesgcm_pkg::CNT_W-1:0] out_bytes,
    output logic        is_tag,
    output logic        final_result
);
    import aesgcm_pkg::*;

    logic [KEY_W-1:0]   key_reg [4];
    logic [IV_HI_W-1:0] ivu_reg;
    logic [63:0]        ivl_reg;
    logic               q_valid, q_pop;
    cmd_t               q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
            ivu_reg    <= '0;
            ivl_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0: key_reg[0] <= cfg_data;
                REG_KEY1: key_reg[1] <= cfg_data;
                REG_KEY2: key_reg[2] <= cfg_data;
                REG_KEY3: key_reg[3] <= cfg_data;
                REG_IVU:  ivu_reg    <= cfg_data[IV_HI_W-1:0];
                REG_IVL:  ivl_reg    <= cfg_data;
                default:  ;
            endcase
        end
    end

    aesgcm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .block_upper(block_upper), .block_lower(block_lower),
        .valid_bytes(valid_bytes), .end_of_message(end_of_message),
        .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
    );

    aesgcm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .key({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .iv({ivu_reg, ivl_reg}),
        .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_upper(out_upper), .out_lower(out_lower), .out_bytes(out_bytes),
        .is_tag(is_tag), .final_result(final_result)
    );
endmodule

// ----- hw/rtl/aesgcm_front.sv -----
module aesgcm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [63:0]              block_upper,
    input  logic [63:0]              block_lower,
    input  logic [aesgcm_pkg::CNT_W-1:0] valid_bytes,
    input  logic                     end_of_message,
    output logic                     q_valid,
    input  logic                     q_pop,
    output aesgcm_pkg::cmd_t         q_head
);
    import aesgcm_pkg::*;

    cmd_t                 mem [FIFO_DEPTH];
    logic                 wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]           cnt_reg, cnt_next;
    cmd_t                 cmd;
    logic                 push;

    // classify: saturate the count on a last item, otherwise a full block
    always_comb
    begin
        cmd.data   = {block_upper, block_lower};
        cmd.last   = end_of_message;
        if (!end_of_message)
            cmd.nbytes = CNT_W'(16);
        else if (valid_bytes > CNT_W'(16))
            cmd.nbytes = CNT_W'(16);
        else
            cmd.nbytes = valid_bytes;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ----- hw/rtl/aesgcm_back.sv -----
module aesgcm_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [255:0]             key,
    input  logic [95:0]              iv,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  aesgcm_pkg::cmd_t         q_head,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [63:0]              out_upper,
    output logic [63:0]              out_lower,
    output logic [aesgcm_pkg::CNT_W-1:0] out_bytes,
    output logic                     is_tag,
    output logic                     final_result
);
    import aesgcm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KEXP  = 4'd1;
    localparam logic [3:0] S_ENCH  = 4'd2;
    localparam logic [3:0] S_ENCJ  = 4'd3;
    localparam logic [3:0] S_DATA  = 4'd4;
    localparam logic [3:0] S_GDATA = 4'd5;
    localparam logic [3:0] S_GLEN  = 4'd6;
    localparam logic [3:0] S_TAG   = 4'd7;
    localparam logic [3:0] S_WOUT  = 4'd8;

    // round keys: 15 x 128
    logic [127:0]  rk_mem [15];
    logic [3:0]    st_reg, st_next;
    logic          ready_reg;
    logic [255:0]  kw_reg;          // sliding pair of key words
    logic [7:0]    rc_reg;
    logic [3:0]    kstep_reg;       // expansion step 0..6
    logic [3:0]    rnd_reg;
    logic [127:0]  aes_reg;
    logic [127:0]  h_reg, tm_reg, acc_reg;
    logic [95:0]   iv_cap_reg;
    logic [31:0]   ctr_reg;
    logic [LEN_W-1:0] len_reg;
    cmd_t          cur_reg;
    logic [127:0]  ct_reg;
    logic [127:0]  gz_reg, gv_reg, ga_reg;
    logic [6:0]    gbit_reg;
    logic          glen_reg;
    logic [127:0]  ob_reg;
    logic [CNT_W-1:0] on_reg;
    logic          otag_reg, ov_reg, then_tag_reg;

    // key expansion step: two new 128-bit round keys from the previous pair
    logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7, t8, t12;
    logic [31:0] n0, n1, n2, n3, n4, n5, n6, n7;
    always_comb
    begin
        {w0, w1, w2, w3, w4, w5, w6, w7} = kw_reg;
        t8 = sub_word({w7[23:0], w7[31:24]}) ^ {rc_reg, 24'h0};
        n0 = w0 ^ t8;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        t12 = sub_word(n3);
        n4 = w4 ^ t12;
        n5 = w5 ^ n4;
        n6 = w6 ^ n5;
        n7 = w7 ^ n6;
    end

    // shared AES round with one round-key read
    logic [127:0] rk_cur, aes_nxt;
    always_comb
    begin
        rk_cur  = rk_mem[rnd_reg];
        aes_nxt = aes_round(aes_reg, rk_cur, rnd_reg != 4'd14);
    end

    // GHASH: 4 bits per cycle over the 128-bit block
    logic [127:0] gz_n, gv_n;
    always_comb
    begin
        gz_n = gz_reg;
        gv_n = gv_reg;
        for (int i = 0; i < 4; i++) begin
            if (ga_reg[127-i]) gz_n = gz_n ^ gv_n;
            gv_n = {1'b0, gv_n[127:1]} ^ (gv_n[0] ? {8'he1, 120'h0} : 128'h0);
        end
    end

    assign q_pop        = (st_reg == S_IDLE) && q_valid && ready_reg && !ov_reg;
    assign out_valid    = ov_reg;
    assign out_upper    = ob_reg[127:64];
    assign out_lower    = ob_reg[63:0];
    assign out_bytes    = on_reg;
    assign is_tag       = otag_reg;
    assign final_result = otag_reg;

    // key words 0..7 come from the key, the rest per step
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid && !ready_reg && !ov_reg)
        begin
            rk_mem[0] <= key[255:128];
            rk_mem[1] <= key[127:0];
        end
        else if (st_reg == S_KEXP)
        begin
            rk_mem[{kstep_reg[2:0], 1'b0} + 4'd2] <= {n0, n1, n2, n3};
            if (kstep_reg != 4'd6)
                rk_mem[{kstep_reg[2:0], 1'b1} + 4'd2] <= {n4, n5, n6, n7};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            ready_reg <= 1'b0;
            ov_reg    <= 1'b0;
            acc_reg   <= '0;
            ctr_reg   <= 32'd2;
            len_reg   <= '0;
        end
        else
        begin
            // result taken; the output states reload it themselves
            if (ov_reg && !out_stall && st_reg != S_WOUT && st_reg != S_TAG)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid && !ov_reg)
                    begin
                        if (!ready_reg)
                        begin
                            kw_reg     <= key;
                            rc_reg     <= 8'h01;
                            kstep_reg  <= 4'd0;
                            iv_cap_reg <= iv;
                            st_reg     <= S_KEXP;
                        end
                        else
                        begin
                            cur_reg <= q_head;
                            if (q_head.nbytes != '0)
                            begin
                                aes_reg <= {iv_cap_reg, ctr_reg} ^ rk_mem[0];
                                rnd_reg <= 4'd1;
                                st_reg  <= S_DATA;
                            end
                            else
                            begin
                                ga_reg   <= acc_reg ^ {64'h0, len_reg, 3'b000};
                                gz_reg   <= '0;
                                gv_reg   <= h_reg;
                                gbit_reg <= '0;
                                glen_reg <= 1'b1;
                                st_reg   <= S_GDATA;
                            end
                        end
                    end
                end
                S_KEXP:
                begin
                    kw_reg    <= {n0, n1, n2, n3, n4, n5, n6, n7};
                    rc_reg    <= xtime(rc_reg);
                    kstep_reg <= kstep_reg + 4'd1;
                    if (kstep_reg == 4'd6)
                    begin
                        aes_reg <= rk_mem[0];
                        rnd_reg <= 4'd1;
                        st_reg  <= S_ENCH;
                    end
                end
                S_ENCH, S_ENCJ, S_DATA:
                begin
                    if (rnd_reg != 4'd14)
                    begin
                        aes_reg <= aes_nxt;
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                    else
                    begin
                        if (st_reg == S_ENCH)
                        begin
                            h_reg   <= aes_nxt;
                            aes_reg <= {iv_cap_reg, 32'd1} ^ rk_mem[0];
                            rnd_reg <= 4'd1;
                            st_reg  <= S_ENCJ;
                        end
                        else if (st_reg == S_ENCJ)
                        begin
                            tm_reg    <= aes_nxt;
                            acc_reg   <= '0;
                            ctr_reg   <= 32'd2;
                            len_reg   <= '0;
                            ready_reg <= 1'b1;
                            st_reg    <= S_IDLE;
                        end
                        else
                        begin
                            ct_reg   <= (cur_reg.data ^ aes_nxt) & byte_mask(cur_reg.nbytes);
                            ga_reg   <= acc_reg ^ ((cur_reg.data ^ aes_nxt)
                                                   & byte_mask(cur_reg.nbytes));
                            gz_reg   <= '0;
                            gv_reg   <= h_reg;
                            gbit_reg <= '0;
                            glen_reg <= 1'b0;
                            ctr_reg  <= ctr_reg + 32'd1;
                            len_reg  <= len_reg + LEN_W'(cur_reg.nbytes);
                            st_reg   <= S_GDATA;
                        end
                    end
                end
                S_GDATA:
                begin
                    gz_reg   <= gz_n;
                    gv_reg   <= gv_n;
                    ga_reg   <= {ga_reg[123:0], 4'h0};
                    gbit_reg <= gbit_reg + 7'd1;
                    if (gbit_reg == 7'd31)
                    begin
                        acc_reg <= gz_n;
                        if (glen_reg)
                            st_reg <= S_TAG;
                        else
                        begin
                            then_tag_reg <= cur_reg.last;
                            st_reg       <= S_WOUT;
                        end
                    end
                end
                S_WOUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ob_reg   <= ct_reg;
                        on_reg   <= cur_reg.nbytes;
                        otag_reg <= 1'b0;
                        ov_reg   <= 1'b1;
                        if (then_tag_reg)
                        begin
                            ga_reg   <= acc_reg ^ {64'h0, len_reg, 3'b000};
                            gz_reg   <= '0;
                            gv_reg   <= h_reg;
                            gbit_reg <= '0;
                            glen_reg <= 1'b1;
                            st_reg   <= S_GDATA;
                        end
                        else
                            st_reg <= S_IDLE;
                    end
                end
                S_TAG:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ob_reg    <= acc_reg ^ tm_reg;
                        on_reg    <= CNT_W'(16);
                        otag_reg  <= 1'b1;
                        ov_reg    <= 1'b1;
                        acc_reg   <= '0;
                        ctr_reg   <= 32'd2;
                        len_reg   <= '0;
                        ready_reg <= 1'b0;
                        st_reg    <= S_IDLE;
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
